### rtl/core/nhtlp_pkg.sv
// shared types and constants for the name hash table core
// no dependencies
package nhtlp_pkg;

  localparam logic [7:0] SPACE_CHAR = 8'h20;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_NOT_FOUND = 2'd1,
    STATUS_TOO_LONG  = 2'd2,
    STATUS_FULL      = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_START,
    ST_PROBE,
    ST_CHECK,
    ST_CMP_RD,
    ST_CMP_CHK,
    ST_WRITE,
    ST_FINISH
  } state_t;

endpackage

### rtl/core/nhtlp_if.sv
// valid/ready channel interfaces for name characters and results
// no dependencies
interface nhtlp_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] name_char;
  logic       last_char;
  logic [7:0] entry_opcode;

  modport source (output valid, command, name_char, last_char, entry_opcode, input ready);
  modport sink (input valid, command, name_char, last_char, entry_opcode, output ready);
endinterface

interface nhtlp_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [7:0] opcode;

  modport source (output valid, status, opcode, input ready);
  modport sink (input valid, status, opcode, output ready);
endinterface

### rtl/core/name_hash_table_linear_probe_core.sv
// keyword-to-opcode hash table with linear probing, top level
// depends on nhtlp_pkg, nhtlp_if, nhtlp_ram, nhtlp_key
//
// key_in carries one name byte per transfer with command, last_char and
// entry_opcode; result_out carries one status/opcode result per name.
// bytes that are not last are taken every cycle in the idle state. the last
// byte starts an insert or a lookup: each probe reads the slot ram, each
// compared character of a lookup reads the char ram, and an insert writes
// its name at one character a cycle. a search is bounded by TABLE_SIZE
// probes. after reset every slot of the slot ram is cleared, during which
// key_in is not ready. the result waits in an output register; bytes of the
// next name are taken while it waits, and the next result is held in the
// finish state until the receiver takes the previous one.
module name_hash_table_linear_probe_core #(
  parameter int TABLE_SIZE = 256,
  parameter int MAX_NAME   = 20
) (
  input  logic           clk,
  input  logic           rst,
  nhtlp_in_if.sink       key_in,
  nhtlp_out_if.source    result_out
);
  import nhtlp_pkg::*;

  localparam int AW  = $clog2(TABLE_SIZE);
  localparam int CW  = $clog2(MAX_NAME);
  localparam int LW  = $clog2(MAX_NAME + 1);
  localparam int NW  = $clog2(TABLE_SIZE + 1);
  localparam int EW  = 1 + LW + 8;
  localparam int CAW = AW + CW;

  state_t          state, state_next;
  logic [AW-1:0]   idx;
  logic [NW-1:0]   probes;
  logic [LW-1:0]   ci;
  logic            op_lookup;
  logic [7:0]      op_opcode;
  status_t         res_status;
  logic [7:0]      res_opcode;

  logic            take;
  logic            key_clear;
  logic [AW-1:0]   key_sum;
  logic [LW-1:0]   kept_length;
  logic            too_long;
  logic [7:0]      key_char;

  logic            slot_we;
  logic [EW-1:0]   slot_wdata;
  logic [EW-1:0]   slot_rdata;
  logic            slot_valid;
  logic [LW-1:0]   slot_length;
  logic [7:0]      slot_opcode;
  logic            char_we;
  logic [CAW-1:0]  char_addr;
  logic [7:0]      char_rdata;
  logic            last_probe;
  logic            out_load;

  assign take        = key_in.valid & key_in.ready;
  assign slot_valid  = slot_rdata[EW-1];
  assign slot_length = slot_rdata[EW-2:8];
  assign slot_opcode = slot_rdata[7:0];
  assign char_addr   = {idx, ci[CW-1:0]};
  assign last_probe  = probes == NW'(TABLE_SIZE - 1);
  assign out_load    = (state == ST_FINISH) && (!result_out.valid || result_out.ready);

  nhtlp_key #(.TABLE_SIZE(TABLE_SIZE), .MAX_NAME(MAX_NAME)) u_key (
    .clk         (clk),
    .rst         (rst),
    .take        (take),
    .command     (key_in.command),
    .name_char   (key_in.name_char),
    .clear       (key_clear),
    .rd_idx      (ci[CW-1:0]),
    .key_sum     (key_sum),
    .kept_length (kept_length),
    .too_long    (too_long),
    .rd_char     (key_char)
  );

  nhtlp_ram #(.DEPTH(TABLE_SIZE), .WIDTH(EW)) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (idx),
    .wdata (slot_wdata),
    .raddr (idx),
    .rdata (slot_rdata)
  );

  nhtlp_ram #(.DEPTH(TABLE_SIZE << CW), .WIDTH(8)) u_char_ram (
    .clk   (clk),
    .we    (char_we),
    .waddr (char_addr),
    .wdata (key_char),
    .raddr (char_addr),
    .rdata (char_rdata)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (idx == AW'(TABLE_SIZE - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (take && key_in.last_char) state_next = ST_START;
      end
      ST_START: begin
        state_next = too_long ? ST_FINISH : ST_PROBE;
      end
      ST_PROBE: state_next = ST_CHECK;
      ST_CHECK: begin
        if (!slot_valid) begin
          state_next = op_lookup ? ST_FINISH : ST_WRITE;
        end else if (op_lookup && slot_length == kept_length) begin
          state_next = ST_CMP_RD;
        end else begin
          state_next = last_probe ? ST_FINISH : ST_PROBE;
        end
      end
      ST_CMP_RD: begin
        state_next = (ci == kept_length) ? ST_FINISH : ST_CMP_CHK;
      end
      ST_CMP_CHK: begin
        if (char_rdata == key_char) begin
          state_next = ST_CMP_RD;
        end else begin
          state_next = last_probe ? ST_FINISH : ST_PROBE;
        end
      end
      ST_WRITE: begin
        if (ci == kept_length) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_load) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    key_in.ready = 1'b0;
    key_clear    = 1'b0;
    slot_we      = 1'b0;
    slot_wdata   = '0;
    char_we      = 1'b0;
    unique case (state)
      ST_CLEAR: slot_we = 1'b1;
      ST_IDLE:  key_in.ready = 1'b1;
      ST_CHECK: begin
        if (!slot_valid && !op_lookup) begin
          slot_we    = 1'b1;
          slot_wdata = {1'b1, kept_length, op_opcode};
        end
      end
      ST_WRITE: char_we = ci != kept_length;
      ST_FINISH: key_clear = out_load;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      idx   <= '0;
    end else begin
      state <= state_next;
      priority case (1'b1)
        state == ST_CLEAR: idx <= idx + AW'(1);
        state == ST_START: idx <= key_sum;
        (state == ST_CHECK && state_next == ST_PROBE) ||
        (state == ST_CMP_CHK && state_next == ST_PROBE): begin
          idx <= (idx == AW'(TABLE_SIZE - 1)) ? '0 : idx + AW'(1);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && take && key_in.last_char) begin
      op_lookup <= key_in.command;
      op_opcode <= key_in.entry_opcode;
    end
    unique case (state)
      ST_START: begin
        probes     <= '0;
        res_status <= STATUS_TOO_LONG;
        res_opcode <= '0;
      end
      ST_CHECK: begin
        ci <= '0;
        if (!slot_valid) begin
          res_status <= op_lookup ? STATUS_NOT_FOUND : STATUS_OK;
        end else if (!(op_lookup && slot_length == kept_length)) begin
          probes     <= probes + NW'(1);
          res_status <= STATUS_FULL;
        end
      end
      ST_CMP_RD: begin
        if (ci == kept_length) begin
          res_status <= STATUS_OK;
          res_opcode <= slot_opcode;
        end
      end
      ST_CMP_CHK: begin
        if (char_rdata == key_char) begin
          ci <= ci + LW'(1);
        end else begin
          probes     <= probes + NW'(1);
          res_status <= STATUS_FULL;
        end
      end
      ST_WRITE: begin
        if (ci != kept_length) ci <= ci + LW'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_out.valid <= 1'b0;
    end else if (out_load) begin
      result_out.valid <= 1'b1;
    end else if (result_out.ready) begin
      result_out.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result_out.status <= res_status;
      result_out.opcode <= res_opcode;
    end
  end

endmodule

### rtl/core/nhtlp_ram.sv
// simple dual port synchronous ram, one write and one registered read per cycle
// no dependencies
module nhtlp_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/nhtlp_key.sv
// key collector: byte sum, length count, space rule and name buffer
// depends on nhtlp_pkg
module nhtlp_key #(
  parameter int TABLE_SIZE = 256,
  parameter int MAX_NAME   = 20
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            take,
  input  logic                            command,
  input  logic [7:0]                      name_char,
  input  logic                            clear,
  input  logic [$clog2(MAX_NAME)-1:0]     rd_idx,
  output logic [$clog2(TABLE_SIZE)-1:0]   key_sum,
  output logic [$clog2(MAX_NAME+1)-1:0]   kept_length,
  output logic                            too_long,
  output logic [7:0]                      rd_char
);
  import nhtlp_pkg::*;

  localparam int AW = $clog2(TABLE_SIZE);
  localparam int CW = $clog2(MAX_NAME);
  localparam int LW = $clog2(MAX_NAME + 1);
  localparam int KW = $clog2(MAX_NAME + 2);
  localparam int SW = AW + 9;

  logic [7:0]    key_buffer [MAX_NAME];
  logic [KW-1:0] key_length;
  logic          space_seen;
  logic          space_next;
  logic [SW-1:0] sum_next;

  assign space_next = space_seen | (command & (name_char == SPACE_CHAR));

  always_comb begin
    sum_next = SW'(key_sum) + SW'(name_char);
    for (int k = 0; k < 4; k++) begin
      if (sum_next >= SW'(TABLE_SIZE)) begin
        sum_next = sum_next - SW'(TABLE_SIZE);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      key_sum     <= '0;
      key_length  <= '0;
      kept_length <= '0;
      space_seen  <= 1'b0;
    end else if (take) begin
      if (key_length <= KW'(MAX_NAME)) begin
        key_length <= key_length + KW'(1);
      end
      space_seen <= space_next;
      if (!space_next) begin
        key_sum <= sum_next[AW-1:0];
        if (kept_length < LW'(MAX_NAME)) begin
          kept_length <= kept_length + LW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && !space_next && kept_length < LW'(MAX_NAME)) begin
      key_buffer[kept_length[CW-1:0]] <= name_char;
    end
  end

  assign too_long = key_length > KW'(MAX_NAME);
  assign rd_char  = key_buffer[rd_idx];

endmodule
